// ----- design/photocathode_pixel_qe_mapper_defines.svh -----
// Assertion macros shared by the photocathode pixel mapper RTL.
`ifndef PHOTOCATHODE_PIXEL_QE_MAPPER_DEFINES_SVH
`define PHOTOCATHODE_PIXEL_QE_MAPPER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PQM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PQM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/pqm_pkg.sv -----
// Package with the grid geometry and efficiency table of the pixel mapper.
`default_nettype none

package pqm_pkg;

   // Grid size and table length.
   localparam int PIXELS_PER_ROW    = 8;
   localparam int PIXEL_ROWS        = 8;
   localparam int EFFICIENCY_POINTS = 15;

   // Field widths.
   localparam int POS_W  = 18;
   localparam int EN_W   = 16;
   localparam int RND_W  = 16;
   localparam int EFF_W  = 17;
   localparam int CODE_W = 8;

   // Geometry in units of mm * 4096, scaled by N * 20 along an axis of N pixels.
   localparam int HALF_SIZE   = 100352;
   localparam int PITCH_UNIT  = 983;
   localparam int DEAD_UNIT   = 3;
   localparam int FRAC_SCALE  = 4096;
   localparam int PITCH       = PITCH_UNIT * FRAC_SCALE;
   localparam int ACT_COL     = (PITCH_UNIT - DEAD_UNIT * PIXELS_PER_ROW) * FRAC_SCALE;
   localparam int ACT_ROW     = (PITCH_UNIT - DEAD_UNIT * PIXEL_ROWS) * FRAC_SCALE;
   localparam int FAIL_OFFSET = 100;

   // Derived widths.
   localparam int SHIFT_W  = $clog2(2 * HALF_SIZE + 1);
   localparam int MAX_N    = (PIXELS_PER_ROW > PIXEL_ROWS) ? PIXELS_PER_ROW : PIXEL_ROWS;
   localparam int AXIS_M_W = $clog2(2 * HALF_SIZE * MAX_N * 20 + 1);
   localparam int COL_W    = (PIXELS_PER_ROW > 1) ? $clog2(PIXELS_PER_ROW) : 1;
   localparam int ROW_W    = (PIXEL_ROWS > 1) ? $clog2(PIXEL_ROWS) : 1;
   localparam int BIN_W    = $clog2(EFFICIENCY_POINTS);
   localparam int FULL_W   = $clog2(PIXELS_PER_ROW * PIXEL_ROWS + FAIL_OFFSET + 1);

   // Efficiency table: energy in eV * 4096, efficiency as a fraction * 65536.
   localparam logic [EN_W-1:0] ENERGY_PTS [EFFICIENCY_POINTS] = '{
      16'd7619,  16'd8028,  16'd8315,  16'd8724,  16'd9339,  16'd9708,
      16'd10158, 16'd10609, 16'd11100, 16'd12739, 16'd13804, 16'd15278,
      16'd16916, 16'd17981, 16'd19005
   };

   localparam logic [EFF_W-1:0] EFF_PTS [EFFICIENCY_POINTS] = '{
      17'd13,    17'd131,   17'd459,   17'd1311,  17'd2621,  17'd5243,
      17'd8520,  17'd11141, 17'd13107, 17'd17039, 17'd17695, 17'd18350,
      17'd14418, 17'd11796, 17'd6554
   };

endpackage

`default_nettype wire

// ----- design/photocathode_pixel_qe_mapper.sv -----
// Photocathode pixel mapper: hit position to pixel code with efficiency test.
//
// Usage:
//   The req_ channel carries one photon hit per transfer: local x and y in mm
//   times 4096, photon energy in eV times 4096 and a 16-bit random draw. The
//   rsp_ channel returns one pixel code per hit, in order: 0 for a dead
//   strip, 1..64 for a pixel, plus 100 when the hit fails the efficiency test.
//   A transfer takes place at a rising edge with valid high and stall low.
//   Throughput is one hit per cycle while the receiver does not stall.
//   The block is a five-register pipeline: clamp and scale, grid and bin
//   search, dead-strip test and table lookup, three products, then the
//   final compare in the output register.
//   When the receiver stalls, the output register holds its result and the
//   earlier stages keep advancing into empty slots; req_stall rises only
//   when every stage holds a hit. Reset empties the pipeline; no result is
//   lost or repeated across a stall.
`default_nettype none

module photocathode_pixel_qe_mapper (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [pqm_pkg::POS_W-1:0]   req_local_x,
   input  wire logic signed [pqm_pkg::POS_W-1:0]   req_local_y,
   input  wire logic        [pqm_pkg::EN_W-1:0]    req_photon_energy,
   input  wire logic        [pqm_pkg::RND_W-1:0]   req_random_draw,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic             [pqm_pkg::CODE_W-1:0]  rsp_pixel_code
);

`include "photocathode_pixel_qe_mapper_defines.svh"

   // Stage enables.
   logic en1, en2, en3, en4, en5;

   // Stage 1 registers.
   logic                              s1_valid_ff;
   logic [pqm_pkg::AXIS_M_W-1:0]      s1_mx_ff, s1_my_ff, s1_mx_in, s1_my_in;
   logic [pqm_pkg::EN_W-1:0]          s1_energy_ff;
   logic [pqm_pkg::RND_W-1:0]         s1_rnd_ff;

   // Stage 2 registers.
   logic                              s2_valid_ff;
   logic [pqm_pkg::AXIS_M_W-1:0]      s2_mx_ff, s2_my_ff;
   logic [pqm_pkg::COL_W-1:0]         s2_col_ff, s2_col_in;
   logic [pqm_pkg::ROW_W-1:0]         s2_row_ff, s2_row_in;
   logic [pqm_pkg::BIN_W-1:0]         s2_bin_ff, s2_bin_in;
   logic                              s2_inbin_ff, s2_inbin_in;
   logic [pqm_pkg::EN_W-1:0]          s2_energy_ff;
   logic [pqm_pkg::RND_W-1:0]         s2_rnd_ff;

   // Stage 3 registers.
   logic                              s3_valid_ff;
   logic                              s3_dead_ff, s3_dead_in;
   logic [pqm_pkg::FULL_W-1:0]        s3_code_ff, s3_code_in;
   logic                              s3_inbin_ff;
   logic [pqm_pkg::EN_W-1:0]          s3_ediff_ff, s3_ediff_in;
   logic [pqm_pkg::EN_W-1:0]          s3_dp_ff, s3_dp_in;
   logic signed [pqm_pkg::EFF_W:0]    s3_dq_ff, s3_dq_in;
   logic [pqm_pkg::EFF_W-1:0]         s3_qk_ff, s3_qk_in;
   logic [pqm_pkg::RND_W-1:0]         s3_rnd_ff;

   // Stage 4 registers.
   localparam int RDP_W = pqm_pkg::RND_W + pqm_pkg::EN_W;
   localparam int QDP_W = pqm_pkg::EFF_W + pqm_pkg::EN_W;
   localparam int EDQ_W = pqm_pkg::EN_W + 1 + pqm_pkg::EFF_W + 1;
   localparam int CMP_W = EDQ_W + 1;
   logic                              s4_valid_ff;
   logic                              s4_dead_ff;
   logic [pqm_pkg::FULL_W-1:0]        s4_code_ff;
   logic                              s4_inbin_ff;
   logic [RDP_W-1:0]                  s4_rdp_ff, s4_rdp_in;
   logic [QDP_W-1:0]                  s4_qdp_ff, s4_qdp_in;
   logic signed [EDQ_W-1:0]           s4_edq_ff, s4_edq_in;

   // Output register.
   logic                              rsp_valid_ff;
   logic [pqm_pkg::CODE_W-1:0]        rsp_code_ff, rsp_code_in;

   // Each stage advances when its slot is empty or its successor advances.
   assign en5 = !rsp_valid_ff || !rsp_stall;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_stall = !en1;

   // Stage 1: clamp both coordinates, shift to the corner and scale by N * 20.
   always_comb begin
      logic signed [pqm_pkg::POS_W-1:0]  cx, cy;
      logic signed [pqm_pkg::POS_W:0]    sx, sy;
      cx = req_local_x;
      cy = req_local_y;
      if (req_local_x < -pqm_pkg::POS_W'(pqm_pkg::HALF_SIZE))
         cx = -pqm_pkg::POS_W'(pqm_pkg::HALF_SIZE);
      else if (req_local_x > pqm_pkg::POS_W'(pqm_pkg::HALF_SIZE))
         cx = pqm_pkg::POS_W'(pqm_pkg::HALF_SIZE);
      if (req_local_y < -pqm_pkg::POS_W'(pqm_pkg::HALF_SIZE))
         cy = -pqm_pkg::POS_W'(pqm_pkg::HALF_SIZE);
      else if (req_local_y > pqm_pkg::POS_W'(pqm_pkg::HALF_SIZE))
         cy = pqm_pkg::POS_W'(pqm_pkg::HALF_SIZE);
      sx = (pqm_pkg::POS_W+1)'(cx) + (pqm_pkg::POS_W+1)'(pqm_pkg::HALF_SIZE);
      sy = (pqm_pkg::POS_W+1)'(cy) + (pqm_pkg::POS_W+1)'(pqm_pkg::HALF_SIZE);
      s1_mx_in = pqm_pkg::AXIS_M_W'(sx[pqm_pkg::SHIFT_W-1:0])
                 * pqm_pkg::AXIS_M_W'(pqm_pkg::PIXELS_PER_ROW * 20);
      s1_my_in = pqm_pkg::AXIS_M_W'(sy[pqm_pkg::SHIFT_W-1:0])
                 * pqm_pkg::AXIS_M_W'(pqm_pkg::PIXEL_ROWS * 20);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_mx_ff     <= s1_mx_in;
         s1_my_ff     <= s1_my_in;
         s1_energy_ff <= req_photon_energy;
         s1_rnd_ff    <= req_random_draw;
      end
   end

   // Stage 2: column and row by comparing against pitch multiples, and the
   // efficiency bin by comparing against the table energies.
   always_comb begin
      s2_col_in   = '0;
      s2_row_in   = '0;
      s2_bin_in   = '0;
      s2_inbin_in = 1'b0;
      for (int k = 1; k < pqm_pkg::PIXELS_PER_ROW; k++) begin
         if (s1_mx_ff >= pqm_pkg::AXIS_M_W'(k * pqm_pkg::PITCH))
            s2_col_in = pqm_pkg::COL_W'(k);
      end
      for (int k = 1; k < pqm_pkg::PIXEL_ROWS; k++) begin
         if (s1_my_ff >= pqm_pkg::AXIS_M_W'(k * pqm_pkg::PITCH))
            s2_row_in = pqm_pkg::ROW_W'(k);
      end
      // Bins are disjoint: a bin holds energies above its lower point up to
      // and including its upper point.
      for (int k = 0; k < pqm_pkg::EFFICIENCY_POINTS - 1; k++) begin
         if (s1_energy_ff > pqm_pkg::ENERGY_PTS[k] &&
             s1_energy_ff <= pqm_pkg::ENERGY_PTS[k+1]) begin
            s2_bin_in   = pqm_pkg::BIN_W'(k);
            s2_inbin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_mx_ff     <= s1_mx_ff;
         s2_my_ff     <= s1_my_ff;
         s2_col_ff    <= s2_col_in;
         s2_row_ff    <= s2_row_in;
         s2_bin_ff    <= s2_bin_in;
         s2_inbin_ff  <= s2_inbin_in;
         s2_energy_ff <= s1_energy_ff;
         s2_rnd_ff    <= s1_rnd_ff;
      end
   end

   // Stage 3: dead-strip test, pixel number and bin table lookup.
   always_comb begin
      logic [pqm_pkg::AXIS_M_W-1:0]  lim_x, lim_y;
      logic [pqm_pkg::BIN_W-1:0]     bin_hi;
      logic [pqm_pkg::EN_W-1:0]      p_lo, p_hi;
      logic [pqm_pkg::EFF_W-1:0]     q_hi;
      // A remainder equal to the active width still counts as active.
      lim_x = pqm_pkg::AXIS_M_W'(s2_col_ff) * pqm_pkg::AXIS_M_W'(pqm_pkg::PITCH)
              + pqm_pkg::AXIS_M_W'(pqm_pkg::ACT_COL);
      lim_y = pqm_pkg::AXIS_M_W'(s2_row_ff) * pqm_pkg::AXIS_M_W'(pqm_pkg::PITCH)
              + pqm_pkg::AXIS_M_W'(pqm_pkg::ACT_ROW);
      s3_dead_in = (s2_mx_ff > lim_x) || (s2_my_ff > lim_y);
      // Pixels are numbered from the top row down, left to right.
      s3_code_in = pqm_pkg::FULL_W'(pqm_pkg::PIXELS_PER_ROW)
                   * (pqm_pkg::FULL_W'(pqm_pkg::PIXEL_ROWS - 1) - pqm_pkg::FULL_W'(s2_row_ff))
                   + pqm_pkg::FULL_W'(s2_col_ff) + pqm_pkg::FULL_W'(1);
      bin_hi      = s2_bin_ff + pqm_pkg::BIN_W'(1);
      p_lo        = pqm_pkg::ENERGY_PTS[s2_bin_ff];
      p_hi        = pqm_pkg::ENERGY_PTS[bin_hi];
      s3_qk_in    = pqm_pkg::EFF_PTS[s2_bin_ff];
      q_hi        = pqm_pkg::EFF_PTS[bin_hi];
      s3_dp_in    = p_hi - p_lo;
      s3_ediff_in = s2_energy_ff - p_lo;
      s3_dq_in    = $signed({1'b0, q_hi}) - $signed({1'b0, s3_qk_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_dead_ff  <= s3_dead_in;
         s3_code_ff  <= s3_code_in;
         s3_inbin_ff <= s2_inbin_ff;
         s3_ediff_ff <= s3_ediff_in;
         s3_dp_ff    <= s3_dp_in;
         s3_dq_ff    <= s3_dq_in;
         s3_qk_ff    <= s3_qk_in;
         s3_rnd_ff   <= s2_rnd_ff;
      end
   end

   // Stage 4: the three products of the interpolation test.
   always_comb begin
      s4_rdp_in = RDP_W'(s3_rnd_ff) * RDP_W'(s3_dp_ff);
      s4_qdp_in = QDP_W'(s3_qk_ff) * QDP_W'(s3_dp_ff);
      s4_edq_in = EDQ_W'($signed({1'b0, s3_ediff_ff})) * EDQ_W'(s3_dq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_dead_ff  <= s3_dead_ff;
         s4_code_ff  <= s3_code_ff;
         s4_inbin_ff <= s3_inbin_ff;
         s4_rdp_ff   <= s4_rdp_in;
         s4_qdp_ff   <= s4_qdp_in;
         s4_edq_ff   <= s4_edq_in;
      end
   end

   // Stage 5: the hit fails when draw * dp exceeds q * dp + (E - p) * dq.
   always_comb begin
      logic signed [CMP_W-1:0]     lhs, rhs;
      logic                        fail;
      logic [pqm_pkg::FULL_W-1:0]  full;
      lhs  = $signed(CMP_W'(s4_rdp_ff));
      rhs  = $signed(CMP_W'(s4_qdp_ff)) + CMP_W'(s4_edq_ff);
      fail = s4_inbin_ff && (lhs > rhs);
      full = s4_code_ff + (fail ? pqm_pkg::FULL_W'(pqm_pkg::FAIL_OFFSET)
                                : pqm_pkg::FULL_W'(0));
      rsp_code_in = s4_dead_ff ? '0 : full[pqm_pkg::CODE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en5) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         rsp_code_ff <= rsp_code_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_code = rsp_code_ff;

   // A full pipeline is the only reason to hold off the sender.
   `PQM_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, s1_valid_ff && s4_valid_ff && rsp_valid_ff, "input stalled with an empty stage")
   // A hit leaving stage 4 lands in the output register.
   `PQM_ASSERT_NEXT(a_handoff, clock, reset, s4_valid_ff && en5, rsp_valid_ff, "result lost between stage 4 and output")
   // A dead-strip hit always reports code zero.
   `PQM_ASSERT_NEXT(a_dead_zero, clock, reset, s4_valid_ff && s4_dead_ff && en5, rsp_pixel_code == '0, "dead strip gave nonzero code")

endmodule

`default_nettype wire

// ----- dv/photocathode_pixel_qe_mapper_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the photocathode pixel mapper: directed and random hits checked against a predictor.

module photocathode_pixel_qe_mapper_tb;

   // Geometry and efficiency table, kept separately from the design package.
   localparam int GRID_COLS = 8;
   localparam int GRID_ROWS = 8;
   localparam int QE_POINTS = 15;
   localparam longint HALF_SPAN = 100352;
   localparam longint PITCH_STEPS = 983;
   localparam longint STRIP_STEPS = 3;
   localparam longint MM_FRAC = 4096;
   localparam longint PIXEL_PITCH = PITCH_STEPS * MM_FRAC;
   localparam longint COL_ACTIVE = (PITCH_STEPS - STRIP_STEPS * GRID_COLS) * MM_FRAC;
   localparam int QE_FAIL_OFFSET = 100;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 40;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 12;

   localparam longint QE_ENERGY [QE_POINTS] = '{
      7619, 8028, 8315, 8724, 9339, 9708, 10158, 10609,
      11100, 12739, 13804, 15278, 16916, 17981, 19005
   };

   localparam longint QE_VALUE [QE_POINTS] = '{
      13, 131, 459, 1311, 2621, 5243, 8520, 11141,
      13107, 17039, 17695, 18350, 14418, 11796, 6554
   };

   typedef logic signed [pqm_pkg::POS_W-1:0] position_type;
   typedef logic [pqm_pkg::EN_W-1:0] energy_type;
   typedef logic [pqm_pkg::RND_W-1:0] draw_type;
   typedef logic [pqm_pkg::CODE_W-1:0] code_type;

   typedef struct {
      position_type x;
      position_type y;
      energy_type energy;
      draw_type draw;
      code_type code;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   position_type req_local_x = '0;
   position_type req_local_y = '0;
   energy_type req_photon_energy = '0;
   draw_type req_random_draw = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   code_type rsp_pixel_code;

   hit_type pending_hits [$];
   int code_errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_rsp = 1'b0;

   photocathode_pixel_qe_mapper dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_local_x       (req_local_x),
      .req_local_y       (req_local_y),
      .req_photon_energy (req_photon_energy),
      .req_random_draw   (req_random_draw),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_code    (rsp_pixel_code)
   );

   always #5 clock = ~clock;

   // The run is abandoned if it goes on far longer than any correct run could.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver stall: random, or held high for the whole of a hold-off stretch.
   always @(posedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(0, 99) < stall_pct);
   end

   // Clamp one coordinate, place it on the grid and flag a dead-strip hit.
   function automatic longint locate_axis(input position_type pos, input longint n,
                                          output bit dead);
      longint v;
      longint m;
      longint idx;
      longint rem;
      v = pos;
      if (v < -HALF_SPAN) v = -HALF_SPAN;
      if (v > HALF_SPAN) v = HALF_SPAN;
      m = (v + HALF_SPAN) * n * 20;
      idx = m / PIXEL_PITCH;
      rem = m - idx * PIXEL_PITCH;
      if (idx > n - 1) idx = n - 1;
      // A remainder equal to the active width still counts as active.
      dead = rem > (PITCH_STEPS - STRIP_STEPS * n) * MM_FRAC;
      return idx;
   endfunction

   // Expected pixel code for one hit, including the efficiency penalty.
   function automatic code_type predict_pixel_code(input position_type x,
                                                   input position_type y,
                                                   input energy_type energy,
                                                   input draw_type draw);
      bit dead_x;
      bit dead_y;
      longint col;
      longint row;
      longint code;
      longint dp;
      longint dq;
      col = locate_axis(x, GRID_COLS, dead_x);
      row = locate_axis(y, GRID_ROWS, dead_y);
      if (dead_x || dead_y) return '0;
      code = GRID_COLS * (GRID_ROWS - 1 - row) + col + 1;
      // A bin holds energies above its lower point up to and including its upper one.
      for (int k = 0; k < QE_POINTS - 1; k++) begin
         if (longint'(energy) > QE_ENERGY[k] && longint'(energy) <= QE_ENERGY[k + 1]) begin
            dp = QE_ENERGY[k + 1] - QE_ENERGY[k];
            dq = QE_VALUE[k + 1] - QE_VALUE[k];
            if (longint'(draw) * dp >
                QE_VALUE[k] * dp + (longint'(energy) - QE_ENERGY[k]) * dq)
               code += QE_FAIL_OFFSET;
         end
      end
      return code_type'(code);
   endfunction

   // Compare every accepted result with the oldest outstanding hit.
   always @(posedge clock) begin
      hit_type oldest;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            if (code_errors < MAX_REPORTS)
               $display("%0t: pixel code %0d arrived with no hit outstanding",
                        $time, rsp_pixel_code);
            code_errors++;
         end else begin
            oldest = pending_hits.pop_front();
            if (rsp_pixel_code !== oldest.code) begin
               if (code_errors < MAX_REPORTS)
                  $display("%0t: hit x=%0d y=%0d e=%0d r=%0d: expected %0d, actual %0d",
                           $time, oldest.x, oldest.y, oldest.energy, oldest.draw,
                           oldest.code, rsp_pixel_code);
               code_errors++;
            end
         end
      end
   end

   // Offer one hit, with random idle cycles first, and record it once transferred.
   task automatic send_hit(input position_type x, input position_type y,
                           input energy_type energy, input draw_type draw);
      hit_type sent;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_local_x <= x;
      req_local_y <= y;
      req_photon_energy <= energy;
      req_random_draw <= draw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent.x = x;
      sent.y = y;
      sent.energy = energy;
      sent.draw = draw;
      sent.code = predict_pixel_code(x, y, energy, draw);
      pending_hits.insert(pending_hits.size(), sent);
   endtask

   // Random coordinate: mostly on the photocathode, some near strip edges, some raw.
   function automatic position_type random_position();
      int pick;
      longint k;
      longint near;
      pick = $urandom_range(0, 9);
      if (pick == 0) return position_type'($urandom());
      if (pick <= 3) begin
         k = $urandom_range(0, GRID_COLS);
         near = k * PIXEL_PITCH + ($urandom_range(0, 1) ? COL_ACTIVE : 0);
         return position_type'(near / (GRID_COLS * 20) - HALF_SPAN
                               + longint'($urandom_range(0, 6)) - 3);
      end
      return position_type'(longint'($urandom_range(0, 2 * HALF_SPAN)) - HALF_SPAN);
   endfunction

   // Random energy: mostly inside the table, some near its points, some anywhere.
   function automatic energy_type random_energy();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 1) return energy_type'($urandom());
      if (pick <= 3)
         return energy_type'(QE_ENERGY[$urandom_range(0, QE_POINTS - 1)]
                             + longint'($urandom_range(0, 4)) - 2);
      return energy_type'($urandom_range(7400, 19300));
   endfunction

   task automatic send_random_hit();
      send_hit(random_position(), random_position(), random_energy(), draw_type'($urandom()));
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct <= recv_pct;
   endtask

   // Corners, clamping, pixel edges and dead strips on both axes.
   task automatic test_grid_edges();
      send_hit(0, 0, 10000, 0);
      send_hit(-100352, -100352, 10000, 65535);
      send_hit(100352, 100352, 10000, 0);
      send_hit(-131072, 131071, 10000, 0);
      send_hit(131071, -131072, 10000, 65535);
      send_hit(100351, 100351, 10000, 0);
      send_hit(-75802, -100352, 10000, 0);
      send_hit(-75801, -100352, 10000, 65535);
      send_hit(-100352, -75801, 10000, 65535);
      send_hit(-75188, 0, 10000, 0);
      send_hit(-75187, -75187, 10000, 0);
   endtask

   // Energies around the ends of the table and exact efficiency ties.
   task automatic test_efficiency_edges();
      send_hit(-60000, -60000, 0, 65535);
      send_hit(-60000, -60000, 7619, 65535);
      send_hit(-60000, -60000, 7620, 65535);
      send_hit(-60000, -60000, 7620, 0);
      send_hit(-60000, -60000, 8028, 131);
      send_hit(-60000, -60000, 8028, 132);
      send_hit(-60000, -60000, 15278, 18350);
      send_hit(-60000, -60000, 15278, 18351);
      send_hit(-60000, -60000, 19005, 65535);
      send_hit(-60000, -60000, 19006, 65535);
      send_hit(-60000, -60000, 65535, 65535);
   endtask

   task automatic test_random_hits(input int count);
      for (int i = 0; i < count; i++) send_random_hit();
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall its input.
   task automatic test_receiver_hold_off();
      set_idling(0, 0);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         test_random_hits(40);
      join
   endtask

   // Wait for every outstanding result, then watch a little longer for strays.
   task automatic wait_for_results();
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_grid_edges();
      test_efficiency_edges();
      set_idling(0, 0);
      test_random_hits(400);
      set_idling(77, 0);
      test_random_hits(350);
      set_idling(0, 77);
      test_random_hits(350);
      set_idling(6, 6);
      test_random_hits(350);
      test_receiver_hold_off();
      req_valid <= 1'b0;
      wait_for_results();
      if (code_errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
